/* rtl/udp_ipv4_header_extractor_core_defines.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef UDP_IPV4_HEADER_EXTRACTOR_CORE_DEFINES_SVH
`define UDP_IPV4_HEADER_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UIHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UIHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/uihe_pkg.sv */
`default_nettype none

package uihe_pkg;

  // Frame byte counter saturates here.
  localparam int unsigned MAX_FRAME_BYTES = 65535;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned MAX_VLAN_TAGS   = 2;

  // Link header kinds selected by the configuration register.
  typedef enum logic [1:0] {
    LINK_RAW     = 2'd0,
    LINK_COOKED1 = 2'd1,
    LINK_COOKED2 = 2'd2,
    LINK_ETH     = 2'd3
  } link_t;

  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
  localparam logic [15:0] FRAG_MASK   = 16'h3FFF;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [3:0]  IP_VERSION4 = 4'd4;

  // IP header start and position of the low byte of the link type field.
  localparam logic [4:0] START_COOKED1 = 5'd16;
  localparam logic [4:0] START_COOKED2 = 5'd20;
  localparam logic [4:0] START_ETH     = 5'd14;
  localparam logic [4:0] KIND_COOKED1  = 5'd15;
  localparam logic [4:0] KIND_COOKED2  = 5'd1;
  localparam logic [4:0] KIND_ETH      = 5'd13;
  localparam logic [4:0] VLAN_TAG_BYTES = 5'd4;

  localparam logic [5:0]  IP_MIN_HDR    = 6'd20;
  localparam logic [4:0]  UDP_HDR_BYTES = 5'd8;
  localparam logic [4:0]  MIN_IP_UDP    = 5'd28;

  // Smallest payload offset an accepted frame can report.
  localparam logic [15:0] MIN_PAYLOAD_OFFSET = 16'd28;

  // Frame state captured on the last byte, checked in the next stage.
  typedef struct packed {
    logic        hdr_ok;
    logic        link_pending;
    logic [4:0]  ip_start;
    logic [5:0]  ihl_bytes;
    logic [15:0] total_len;
    logic [15:0] udp_len;
    logic [15:0] caplen;
    logic [63:0] addrs;
    logic [31:0] ports;
  } frame_sum_t;

endpackage

`default_nettype wire

/* rtl/udp_ipv4_header_extractor_core.sv */
// Channel   | Handshake           | Payload
// ----------+---------------------+--------------------------------------------
// input     | in_valid / in_ready | in_frame_byte, in_last_byte
// result    | out_valid/out_ready | out_udp_valid, addresses, ports, payload
// config    | cfg_wr_en           | cfg_wr_data (link type)
//
// One frame byte is taken per cycle while no stalled result holds back a last byte;
// the byte pipeline never stalls itself. A result follows the transfer of the last byte:
// the byte sits in the input register, the header update loads the summary register,
// then the length checks load the output register.
// Reset (rst_n, synchronous) clears all control and frame state, link type = 3.
// Stalls on out_ready back up only through stages that hold a last byte.
`default_nettype none

module udp_ipv4_header_extractor_core import uihe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_udp_valid,
  output logic [31:0]      out_source_address,
  output logic [31:0]      out_destination_address,
  output logic [15:0]      out_source_port,
  output logic [15:0]      out_destination_port,
  output logic [15:0]      out_payload_offset,
  output logic [15:0]      out_payload_length
);

  // Configuration register.
  logic [1:0] link_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= LINK_ETH;
    end else if (cfg_wr_en) begin
      link_type_r <= cfg_wr_data;
    end
  end

  // Pipeline flow control.
  logic in_valid_r, fin_valid_r, out_valid_r;
  logic out_free, fin_free, proc;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    fin_free = !fin_valid_r || out_free;
    proc     = in_valid_r && (!in_last_r || fin_free);
    in_ready = !in_valid_r || proc;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_frame_byte;
      in_last_r <= in_last_byte;
    end
  end

  // Frame state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [4:0]       start_r, start_nxt;
  logic [1:0]       tag_r, tag_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [5:0]       ihl_r, ihl_nxt;
  logic [15:0]      total_r, total_nxt;
  logic [63:0]      addr_r, addr_nxt;
  logic [31:0]      ports_r, ports_nxt;
  logic [15:0]      udp_len_r, udp_len_nxt;
  logic [1:0]       flink_r, flink_nxt;
  logic             pend_r, pend_nxt;
  logic [4:0]       kidx_r, kidx_nxt;

  logic [1:0]       flink_e;
  logic             pend_e;
  logic [4:0]       start_e, kidx_e;
  logic [5:0]       ihl_e;
  logic [15:0]      rel, udp_rel, kind;
  logic             first, active, in_ip, vlan_hit;
  frame_sum_t       sum_nxt;

  // Per-byte header walk: link header first, then IPv4 and UDP fields.
  always_comb begin
    first  = (pos_r == '0);
    active = (pos_r != POS_W'(MAX_FRAME_BYTES));

    flink_e = first ? link_type_r : flink_r;
    pend_e  = first ? (link_type_r != LINK_RAW) : pend_r;
    start_e = start_r;
    kidx_e  = kidx_r;
    if (first) begin
      case (link_type_r)
        LINK_RAW: begin
          start_e = '0;
          kidx_e  = '0;
        end
        LINK_COOKED1: begin
          start_e = START_COOKED1;
          kidx_e  = KIND_COOKED1;
        end
        LINK_COOKED2: begin
          start_e = START_COOKED2;
          kidx_e  = KIND_COOKED2;
        end
        default: begin
          start_e = START_ETH;
          kidx_e  = KIND_ETH;
        end
      endcase
    end

    pos_nxt     = pos_r;
    start_nxt   = start_r;
    tag_nxt     = tag_r;
    prev_nxt    = prev_r;
    hdr_ok_nxt  = hdr_ok_r;
    ihl_nxt     = ihl_r;
    total_nxt   = total_r;
    addr_nxt    = addr_r;
    ports_nxt   = ports_r;
    udp_len_nxt = udp_len_r;
    flink_nxt   = flink_r;
    pend_nxt    = pend_r;
    kidx_nxt    = kidx_r;

    rel      = pos_r - {11'd0, start_e};
    in_ip    = !pend_e && (pos_r >= {11'd0, start_e});
    kind     = {prev_r, in_byte_r};
    vlan_hit = (flink_e == LINK_ETH) && ((kind == ETYPE_VLAN) || (kind == ETYPE_QINQ))
               && (tag_r < 2'(MAX_VLAN_TAGS));
    ihl_e    = (in_ip && rel == 16'd0) ? {in_byte_r[3:0], 2'b00} : ihl_r;
    udp_rel  = rel - {10'd0, ihl_e};

    if (active) begin
      flink_nxt = flink_e;
      pend_nxt  = pend_e;
      start_nxt = start_e;
      kidx_nxt  = kidx_e;
      ihl_nxt   = ihl_e;

      // IPv4 header fields.
      if (in_ip) begin
        case (rel)
          16'd0: begin
            if (in_byte_r[7:4] != IP_VERSION4 || ihl_e < IP_MIN_HDR) begin
              hdr_ok_nxt = 1'b0;
            end
          end
          16'd3: total_nxt = kind;
          16'd7: begin
            if ((kind & FRAG_MASK) != 16'd0) begin
              hdr_ok_nxt = 1'b0;
            end
          end
          16'd9: begin
            if (in_byte_r != PROTO_UDP) begin
              hdr_ok_nxt = 1'b0;
            end
          end
          default: begin
            if (rel >= 16'd12 && rel <= 16'd19) begin
              addr_nxt = {addr_r[55:0], in_byte_r};
            end
          end
        endcase
        // UDP header fields after the IP options.
        if (ihl_e >= IP_MIN_HDR && rel >= {10'd0, ihl_e}) begin
          if (udp_rel < 16'd4) begin
            ports_nxt = {ports_r[23:0], in_byte_r};
          end else if (udp_rel == 16'd5) begin
            udp_len_nxt = kind;
          end
        end
      end

      // Link type field, with VLAN tags skipped.
      if (pend_e && pos_r == {11'd0, kidx_e}) begin
        if (vlan_hit) begin
          tag_nxt   = tag_r + 2'd1;
          start_nxt = start_e + VLAN_TAG_BYTES;
          kidx_nxt  = start_e + VLAN_TAG_BYTES - 5'd1;
        end else begin
          pend_nxt = 1'b0;
          if (kind != ETYPE_IPV4) begin
            hdr_ok_nxt = 1'b0;
          end
        end
      end

      prev_nxt = in_byte_r;
      pos_nxt  = pos_r + 1'b1;
    end

    sum_nxt.hdr_ok       = hdr_ok_nxt;
    sum_nxt.link_pending = pend_nxt;
    sum_nxt.ip_start     = start_nxt;
    sum_nxt.ihl_bytes    = ihl_nxt;
    sum_nxt.total_len    = total_nxt;
    sum_nxt.udp_len      = udp_len_nxt;
    sum_nxt.caplen       = pos_nxt;
    sum_nxt.addrs        = addr_nxt;
    sum_nxt.ports        = ports_nxt;
  end

  // Frame state registers; the last byte returns them to the cleared state.
  always_ff @(posedge clk) begin
    if (!rst_n || (proc && in_last_r)) begin
      pos_r     <= '0;
      start_r   <= '0;
      tag_r     <= '0;
      prev_r    <= '0;
      hdr_ok_r  <= 1'b1;
      ihl_r     <= '0;
      total_r   <= '0;
      addr_r    <= '0;
      ports_r   <= '0;
      udp_len_r <= '0;
      flink_r   <= LINK_RAW;
      pend_r    <= 1'b0;
      kidx_r    <= '0;
    end else if (proc) begin
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      tag_r     <= tag_nxt;
      prev_r    <= prev_nxt;
      hdr_ok_r  <= hdr_ok_nxt;
      ihl_r     <= ihl_nxt;
      total_r   <= total_nxt;
      addr_r    <= addr_nxt;
      ports_r   <= ports_nxt;
      udp_len_r <= udp_len_nxt;
      flink_r   <= flink_nxt;
      pend_r    <= pend_nxt;
      kidx_r    <= kidx_nxt;
    end
  end

  // Summary register holding the finished frame state.
  frame_sum_t fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= proc && in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_free && proc && in_last_r) begin
      fin_r <= sum_nxt;
    end
  end

  // Length checks against the captured count.
  logic [17:0] cap18, start18, ihl18, tot18, udp18, hdr_end18;
  logic        reject;

  always_comb begin
    cap18     = {2'd0, fin_r.caplen};
    start18   = {13'd0, fin_r.ip_start};
    ihl18     = {12'd0, fin_r.ihl_bytes};
    tot18     = {2'd0, fin_r.total_len};
    udp18     = {2'd0, fin_r.udp_len};
    hdr_end18 = start18 + ihl18;
    reject = !fin_r.hdr_ok || fin_r.link_pending
          || (cap18 < 18'(MIN_IP_UDP)) || (cap18 < start18 + 18'(MIN_IP_UDP))
          || (fin_r.ihl_bytes < IP_MIN_HDR)
          || (cap18 < hdr_end18 + 18'(UDP_HDR_BYTES))
          || (tot18 < ihl18 + 18'(UDP_HDR_BYTES)) || (cap18 < start18 + tot18)
          || (udp18 < 18'(UDP_HDR_BYTES)) || (udp18 > tot18 - ihl18)
          || (cap18 < hdr_end18 + udp18);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid_r) begin
      if (reject) begin
        out_udp_valid           <= 1'b0;
        out_source_address      <= '0;
        out_destination_address <= '0;
        out_source_port         <= '0;
        out_destination_port    <= '0;
        out_payload_offset      <= '0;
        out_payload_length      <= '0;
      end else begin
        out_udp_valid           <= 1'b1;
        out_source_address      <= fin_r.addrs[63:32];
        out_destination_address <= fin_r.addrs[31:0];
        out_source_port         <= fin_r.ports[31:16];
        out_destination_port    <= fin_r.ports[15:0];
        out_payload_offset      <= 16'(hdr_end18 + 18'(UDP_HDR_BYTES));
        out_payload_length      <= fin_r.udp_len - 16'(UDP_HDR_BYTES);
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/uihe_checker.sv */
`default_nettype none

`include "udp_ipv4_header_extractor_core_defines.svh"

module uihe_checker import uihe_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_udp_valid,
  input wire logic [31:0] out_source_address,
  input wire logic [31:0] out_destination_address,
  input wire logic [15:0] out_source_port,
  input wire logic [15:0] out_destination_port,
  input wire logic [15:0] out_payload_offset,
  input wire logic [15:0] out_payload_length
);

  // Count of last bytes transferred whose results have not left yet.
  logic [2:0] owed_r;
  logic       last_xfer, out_xfer;

  assign last_xfer = in_valid && in_ready && in_last_byte;
  assign out_xfer  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else begin
      owed_r <= owed_r + {2'd0, last_xfer} - {2'd0, out_xfer};
    end
  end

  // A stalled result keeps its contents.
  `UIHE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_udp_valid) && $stable(out_source_address) && $stable(out_payload_offset), "result changed while stalled")

  // Every result belongs to a frame whose last byte was transferred.
  `UIHE_ASSERT_NOW(a_no_extra, out_valid, owed_r != 3'd0, "result without a last byte")

  // A rejected frame reports all zero fields.
  `UIHE_ASSERT_NOW(a_reject_zero, out_valid && !out_udp_valid, out_source_address == 32'd0 && out_destination_address == 32'd0 && out_source_port == 16'd0 && out_destination_port == 16'd0 && out_payload_offset == 16'd0 && out_payload_length == 16'd0, "rejected frame has nonzero fields")

  // An accepted frame has its payload after at least the minimum headers.
  `UIHE_ASSERT_NOW(a_offset_min, out_valid && out_udp_valid, out_payload_offset >= MIN_PAYLOAD_OFFSET, "payload offset too small")

endmodule

bind udp_ipv4_header_extractor_core uihe_checker u_uihe_checker (.*);

`default_nettype wire
